// ===== hw/rtl/cda_pkg.sv =====
// shared widths, command codes and calendar constants for the date adder
package cda_pkg;

  // field widths
  localparam int unsigned YEAR_W    = 16;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned AMT_W     = 16;
  localparam int unsigned DAY_ACC_W = 17;

  // amount limit and year ceiling
  localparam int unsigned MAX_AMOUNT = 65535;
  localparam int unsigned YEAR_MAX   = 65535;

  // month carry divider
  localparam int unsigned MONTHS_PER_YEAR = 12;
  localparam int unsigned DIV_W           = AMT_W + 1;
  localparam int unsigned REM_W           = MONTH_W;

  // divide by three through the reciprocal (2^17 + 1) / 3, after a shift by two
  localparam int unsigned DIV3_RECIP_W = 16;
  localparam int unsigned DIV3_PROD_W  = 32;
  localparam int unsigned DIV3_SHIFT   = 17;
  localparam logic [DIV3_RECIP_W-1:0] DIV3_RECIP = 16'hAAAB;

  // command codes
  localparam logic [1:0] MODE_SET        = 2'd0;
  localparam logic [1:0] MODE_ADD_DAYS   = 2'd1;
  localparam logic [1:0] MODE_ADD_MONTHS = 2'd2;
  localparam logic [1:0] MODE_ADD_YEARS  = 2'd3;

  // divisibility by 25 through the modular inverse of 25 mod 2^16
  localparam logic [YEAR_W-1:0] LEAP_INV25     = 16'd23593;
  localparam logic [YEAR_W-1:0] LEAP_DIV25_MAX = 16'd2621;

  // month numbers and lengths
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] LEN_FEB_LEAP = 5'd29;
  localparam logic [DAY_W-1:0] LEN_FEB      = 5'd28;
  localparam logic [DAY_W-1:0] LEN_LONG     = 5'd31;
  localparam logic [DAY_W-1:0] LEN_SHORT    = 5'd30;

endpackage

// ===== hw/rtl/cda_month_len.sv =====
// month length lookup with a registered gregorian leap-year flag
module cda_month_len import cda_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [YEAR_W-1:0]  year_i,
  input  logic [MONTH_W-1:0] month_i,
  output logic [DAY_W-1:0]   len_o
);

  logic [2*YEAR_W-1:0] prod;
  logic                div25;
  logic                leap_d;
  logic                leap_q;
  logic                is_long;

  // year is a multiple of 25 when its product with the inverse lands low
  assign prod  = year_i * LEAP_INV25;
  assign div25 = (prod[YEAR_W-1:0] <= LEAP_DIV25_MAX);

  // multiple of 4 but not of 100, or multiple of 400
  assign leap_d = ((year_i[1:0] == 2'b00) && !div25) ||
                  ((year_i[3:0] == 4'b0000) && div25);

  // flag is registered, so it follows the year in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leap_q <= 1'b1;
    end else begin
      leap_q <= leap_d;
    end
  end

  // odd months up to july and even months after it are long
  assign is_long = ((month_i <= MONTH_JUL) && month_i[0]) ||
                   ((month_i > MONTH_JUL) && !month_i[0]);

  always_comb begin
    if (month_i == MONTH_FEB) begin
      len_o = leap_q ? LEN_FEB_LEAP : LEN_FEB;
    end else if (is_long) begin
      len_o = LEN_LONG;
    end else begin
      len_o = LEN_SHORT;
    end
  end

endmodule

// ===== hw/rtl/cda_div12.sv =====
// divider by twelve for the month carry, by shift and reciprocal multiply
module cda_div12 import cda_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_W-1:0]   dividend_i,
  output logic               done_o,
  output logic [DIV_W-1:0]   quot_o,
  output logic [REM_W-1:0]   rem_o
);

  logic                   busy_q;
  logic                   done_q;
  logic [DIV_W-1:0]       x_q;
  logic [DIV_W-3:0]       quarter;
  logic [DIV3_PROD_W-1:0] prod;
  logic [DIV_W-3:0]       quot_d;
  logic [DIV_W-3:0]       quot_q;

  // x / 12 is (x / 4) / 3, the second step by reciprocal multiply
  assign quarter = x_q[DIV_W-1:2];
  assign prod    = DIV3_PROD_W'(quarter) * DIV3_PROD_W'(DIV3_RECIP);
  assign quot_d  = prod[DIV3_SHIFT +: (DIV_W-2)];

  // capture, multiply, then done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  // dividend held until the next start, quotient registered
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= dividend_i;
    end
    if (busy_q) begin
      quot_q <= quot_d;
    end
  end

  // remainder below twelve, so the low four bits of x - 8q - 4q are enough
  assign done_o = done_q;
  assign quot_o = DIV_W'(quot_q);
  assign rem_o  = x_q[REM_W-1:0] - {quot_q[0], 3'b000} - {quot_q[1:0], 2'b00};

endmodule

// ===== hw/rtl/calendar_date_adder.sv =====
// gregorian date register with set, add-days, add-months and add-years commands
// set and add-years go from accept through ST_FIN to out_valid_o; add-months goes
//   through ST_MSUM, and ST_DIV when the month count passes twelve (two-step divider by twelve)
// add-days: ST_CARRY and ST_SETTLE, then ST_WALK with one month per step, then ST_FIN
// one transaction in flight; in_stall_o is low only while idle, output is registered
// reset: date goes to year 0, month 1, day 1, no result pending
module calendar_date_adder import cda_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [YEAR_W-1:0]  new_year_i,
  input  logic [MONTH_W-1:0] new_month_i,
  input  logic [DAY_W-1:0]   new_day_i,
  input  logic [AMT_W-1:0]   amount_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [YEAR_W-1:0]  year_out_o,
  output logic [MONTH_W-1:0] month_out_o,
  output logic [DAY_W-1:0]   day_out_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CARRY  = 3'd1;
  localparam logic [2:0] ST_SETTLE = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_MSUM   = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [YEAR_W-1:0]    year_q, year_d;
  logic [MONTH_W-1:0]   month_q, month_d;
  logic [DAY_ACC_W-1:0] day_q, day_d;
  logic [DIV_W-1:0]     msum_q, msum_d;
  logic                 out_valid_q, out_valid_d;
  logic [YEAR_W-1:0]    year_out_q, year_out_d;
  logic [MONTH_W-1:0]   month_out_q, month_out_d;
  logic [DAY_W-1:0]     day_out_q, day_out_d;
  logic [AMT_W-1:0]     amt_c;
  logic [DAY_W-1:0]     len;
  logic                 day_gt;
  logic                 div_start;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quot;
  logic [REM_W-1:0]     div_rem;

  // year plus increment, held at the ceiling
  function automatic logic [YEAR_W-1:0] sat_year(input logic [YEAR_W-1:0] y,
                                                 input logic [DIV_W-1:0]  inc);
    logic [DIV_W:0] sum;
    sum = (DIV_W+1)'(y) + (DIV_W+1)'(inc);
    return (sum > (DIV_W+1)'(YEAR_MAX)) ? YEAR_W'(YEAR_MAX) : sum[YEAR_W-1:0];
  endfunction

  // amount limit
  assign amt_c = (32'(amount_i) > 32'(MAX_AMOUNT)) ? AMT_W'(MAX_AMOUNT) : amount_i;

  // length of the current month
  cda_month_len u_month_len (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .year_i  (year_q),
    .month_i (month_q),
    .len_o   (len)
  );

  assign day_gt = (day_q > DAY_ACC_W'(len));

  // month carry divider
  cda_div12 u_div12 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (msum_q - DIV_W'(1)),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    year_d      = year_q;
    month_d     = month_q;
    day_d       = day_q;
    msum_d      = msum_q;
    out_valid_d = out_valid_q;
    year_out_d  = year_out_q;
    month_out_d = month_out_q;
    day_out_d   = day_out_q;
    div_start   = 1'b0;

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_i)
            MODE_SET: begin
              year_d  = new_year_i;
              month_d = new_month_i;
              day_d   = DAY_ACC_W'(new_day_i);
              state_d = ST_FIN;
            end
            MODE_ADD_DAYS: begin
              day_d   = day_q + DAY_ACC_W'(amt_c);
              state_d = ST_CARRY;
            end
            MODE_ADD_MONTHS: begin
              msum_d  = DIV_W'(month_q) + DIV_W'(amt_c);
              state_d = ST_MSUM;
            end
            MODE_ADD_YEARS: begin
              year_d  = sat_year(year_q, DIV_W'(amt_c));
              state_d = ST_FIN;
            end
          endcase
        end
      end
      // fold a loaded month past december into the year
      ST_CARRY: begin
        if (month_q > MONTH_DEC) begin
          month_d = month_q - MONTH_DEC;
          year_d  = sat_year(year_q, DIV_W'(1));
        end
        state_d = ST_SETTLE;
      end
      // let the leap flag follow the year
      ST_SETTLE: begin
        state_d = ST_WALK;
      end
      // one month per cycle; january needs no leap flag after a year step
      ST_WALK: begin
        if (day_gt) begin
          day_d = day_q - DAY_ACC_W'(len);
          if (month_q == MONTH_DEC) begin
            month_d = MONTH_JAN;
            year_d  = sat_year(year_q, DIV_W'(1));
          end else begin
            month_d = month_q + MONTH_W'(1);
          end
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_MSUM: begin
        if (msum_q > DIV_W'(MONTHS_PER_YEAR)) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          month_d = msum_q[MONTH_W-1:0];
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          year_d  = sat_year(year_q, div_quot);
          month_d = MONTH_W'(div_rem) + MONTH_W'(1);
          state_d = ST_FIN;
        end
      end
      // hand the date to the output register once it is free
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          year_out_d  = year_q;
          month_out_d = month_q;
          day_out_d   = day_q[DAY_W-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and date state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      year_q      <= '0;
      month_q     <= MONTH_JAN;
      day_q       <= DAY_ACC_W'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      year_q      <= year_d;
      month_q     <= month_d;
      day_q       <= day_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    msum_q      <= msum_d;
    year_out_q  <= year_out_d;
    month_out_q <= month_out_d;
    day_out_q   <= day_out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign year_out_o  = year_out_q;
  assign month_out_o = month_out_q;
  assign day_out_o   = day_out_q;

`ifndef SYNTH
  // month carry is done before the walk starts
  ap_walk_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> month_q <= MONTH_DEC)
    else $error("walk entered with month past december");

  // every walk step shrinks the day count
  ap_walk_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK && day_gt |=> day_q < $past(day_q))
    else $error("walk step did not reduce the day count");

  // divider only finishes while the sequencer waits for it
  ap_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the month carry");

  // finished date shows up on the output
  ap_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && (!out_valid_q || !out_stall_i)
    |=> out_valid_o && year_out_o == $past(year_q) && month_out_o == $past(month_q))
    else $error("finished transaction not presented on the output");
`endif

endmodule
